// ===== rtl/normalized_blendshape_mix_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the normalized blendshape mix unit
// Property templates shared by the checker, one assertion per use.
// ----------------------------------------------------------------------------
`ifndef NORMALIZED_BLENDSHAPE_MIX_UNIT_ASSERT_SVH
`define NORMALIZED_BLENDSHAPE_MIX_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define NBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nbm: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define NBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nbm: same-cycle check failed");

`endif

// ===== rtl/nbm_pkg.sv =====
// ----------------------------------------------------------------------------
// nbm_pkg
// Shared constants, operation codes and word types of the blendshape mixer.
// ----------------------------------------------------------------------------
package nbm_pkg;

    // Weight store geometry and shape count register.
    localparam int MAX_SHAPES = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;

    // Sum of squares: 2^28 plus up to MAX_SHAPES terms of at most 2^30.
    localparam int T_W = 31 + $clog2(MAX_SHAPES + 1);
    localparam logic [T_W-1:0] T_INIT = T_W'(1) << 28;

    // Reciprocal square root search: scale bits 30 down to 0, bound 2^88.
    localparam int ROOT_TOP_BIT = 30;
    localparam int ROOT_LIMIT_EXP = 88;
    localparam logic [31:0] SCALE_ONE = 32'h4000_0000;

    // Operation codes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_TERM   = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDX_W-1:0]  shape_index;
        logic signed [15:0] weight_value;
        logic signed [31:0] neutral_position;
        logic signed [31:0] neutral_normal;
        logic signed [31:0] delta_position;
        logic signed [31:0] delta_normal;
        logic              last_term;
        logic              last_component;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] position_out;
        logic signed [31:0] normal_out;
        logic              frame_end;
    } t_out_word;

endpackage

// ===== rtl/nbm_rsqrt.sv =====
// ----------------------------------------------------------------------------
// nbm_rsqrt
// Bit-by-bit search of the largest scale s with s*s*T <= 2^88, that is
// floor(2^44 / sqrt(T)) in Q2.30, using shifted adds instead of products.
// ----------------------------------------------------------------------------
module nbm_rsqrt
    import nbm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [T_W-1:0] i_t,
    output logic           o_done,
    output logic [31:0]    o_scale
);

    localparam int W = T_W + 2 * ROOT_TOP_BIT + 1;
    localparam logic [W-1:0] LIMIT = W'(1) << ROOT_LIMIT_EXP;

    // P = s*s*T, A = s*T << (b+1), D = T << 2b for the bit b under test.
    logic [W-1:0] r_p;
    logic [W-1:0] r_a;
    logic [W-1:0] r_d;
    logic [W-1:0] r_tmp;
    logic [W-1:0] r_anext;
    logic [31:0]  r_s;
    logic [31:0]  r_scale;
    logic [4:0]   r_bit;
    logic         r_busy;
    logic         r_phase;
    logic         r_done;

    logic [W-1:0] cand;
    logic         take;
    logic [31:0]  n_s;

    // Candidate (s + 2^b)^2 * T and its test against the bound.
    always_comb begin
        cand = r_tmp + r_d;
        take = (cand <= LIMIT);
        n_s  = take ? (r_s | (32'd1 << r_bit)) : r_s;
    end

    // Per bit: first the partial sums, then test and update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_scale <= SCALE_ONE;
        end else begin
            // Done pulses for one cycle after the test of bit zero.
            r_done <= !i_start && r_busy && r_phase && (r_bit == 5'd0);
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_bit   <= 5'(ROOT_TOP_BIT);
                r_p     <= '0;
                r_a     <= '0;
                r_d     <= W'(i_t) << (2 * ROOT_TOP_BIT);
                r_s     <= '0;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_tmp   <= r_p + r_a;
                    r_anext <= (r_a >> 1) + r_d;
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    r_s     <= n_s;
                    r_d     <= r_d >> 2;
                    if (take) begin
                        r_p <= cand;
                        r_a <= r_anext;
                    end else begin
                        r_a <= r_a >> 1;
                    end
                    if (r_bit == 5'd0) begin
                        r_busy  <= 1'b0;
                        r_scale <= n_s;
                    end else begin
                        r_bit <= r_bit - 5'd1;
                    end
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_scale = r_scale;

endmodule

// ===== rtl/normalized_blendshape_mix_unit.sv =====
// ----------------------------------------------------------------------------
// normalized_blendshape_mix_unit
// Load, an ignored opcode or a non-last term beyond the shape count keep the
// block idle. A term within the count uses the weight memory and the shared
// 33x33 multiplier; a last term then finishes position and normal (magnitude,
// two partial products, add, saturate) and waits out any output stall. Commit
// sums the squared weights, then runs the scale search. Reset clears control,
// sets the scale to 1.0 and the accumulators to zero; weights stay unwritten.
// ----------------------------------------------------------------------------
module normalized_blendshape_mix_unit
    import nbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SUM_RD    = 4'd1;
    localparam logic [3:0] S_SUM_MUL   = 4'd2;
    localparam logic [3:0] S_SUM_ACC   = 4'd3;
    localparam logic [3:0] S_ROOT_GO   = 4'd4;
    localparam logic [3:0] S_ROOT_WAIT = 4'd5;
    localparam logic [3:0] S_TERM_RD   = 4'd6;
    localparam logic [3:0] S_TERM_MP   = 4'd7;
    localparam logic [3:0] S_TERM_MN   = 4'd8;
    localparam logic [3:0] S_TERM_AN   = 4'd9;
    localparam logic [3:0] S_FIN_MAG   = 4'd10;
    localparam logic [3:0] S_FIN_LO    = 4'd11;
    localparam logic [3:0] S_FIN_HI    = 4'd12;
    localparam logic [3:0] S_FIN_ADD   = 4'd13;
    localparam logic [3:0] S_FIN_SAT   = 4'd14;
    localparam logic [3:0] S_OUT       = 4'd15;

    localparam logic [64:0] ROUND_HALF = 65'd1 << 43;

    logic [3:0]         r_state;
    t_in_word           r_item;
    logic [CNT_W-1:0]   r_shape_count;
    logic [CNT_W-1:0]   r_cnt;
    logic [T_W-1:0]     r_t;
    logic [15:0]        r_wmem [MAX_SHAPES];
    logic [15:0]        r_rd_data;
    logic signed [65:0] r_prod;
    logic signed [63:0] r_pacc;
    logic signed [63:0] r_nacc;
    logic [63:0]        r_mag;
    logic               r_neg;
    logic [64:0]        r_lo;
    logic [95:0]        r_full;
    logic               r_fin_sel;
    logic signed [31:0] r_pos_res;
    logic signed [31:0] r_nrm_res;
    t_out_word          r_out;
    logic               r_out_valid;

    logic               in_accept;
    logic [CNT_W-1:0]   count_used;
    logic [IDX_W-1:0]   rd_addr;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] w_ext;
    logic signed [63:0] fin_acc;
    logic signed [31:0] fin_neutral;
    logic signed [53:0] fin_scaled;
    logic signed [53:0] fin_sum;
    logic signed [31:0] fin_sat;
    logic               out_free;
    logic               root_start;
    logic               root_done;
    logic [31:0]        scale;

    // Saturating add of a weight-times-delta product into an accumulator.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [65:0] p);
        logic signed [64:0] s;
        s = {a[63], a} + p[64:0];
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign root_start  = (r_state == S_ROOT_GO);

    // Shape count in use, limited to the store depth.
    assign count_used = (r_shape_count > CNT_W'(MAX_SHAPES)) ? CNT_W'(MAX_SHAPES)
                                                             : r_shape_count;

    // Commit walks the store by counter; terms read their own shape.
    assign rd_addr = (r_state == S_SUM_RD) ? r_cnt[IDX_W-1:0] : r_item.shape_index;

    // Weight memory: one write port at accept, one registered read port.
    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_data.opcode == OP_LOAD) begin
            r_wmem[i_in_data.shape_index] <= i_in_data.weight_value;
        end
        r_rd_data <= r_wmem[rd_addr];
    end

    // Operand selection for the shared signed 33x33 multiplier.
    always_comb begin
        w_ext = {{17{r_rd_data[15]}}, r_rd_data};
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SUM_MUL: begin
                mul_a = w_ext;
                mul_b = w_ext;
            end
            S_TERM_MP: begin
                mul_a = w_ext;
                mul_b = {r_item.delta_position[31], r_item.delta_position};
            end
            S_TERM_MN: begin
                mul_a = w_ext;
                mul_b = {r_item.delta_normal[31], r_item.delta_normal};
            end
            S_FIN_LO: begin
                mul_a = {1'b0, r_mag[31:0]};
                mul_b = {1'b0, scale};
            end
            S_FIN_HI: begin
                mul_a = {1'b0, r_mag[63:32]};
                mul_b = {1'b0, scale};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Finishing arithmetic: sign, neutral offset and 32-bit saturation.
    always_comb begin
        fin_acc     = r_fin_sel ? r_nacc : r_pacc;
        fin_neutral = r_fin_sel ? r_item.neutral_normal : r_item.neutral_position;
        fin_scaled  = r_neg ? -$signed({2'b00, r_full[95:44]})
                            : $signed({2'b00, r_full[95:44]});
        fin_sum     = fin_scaled + 54'(fin_neutral);
        if (fin_sum > 54'sd2147483647) begin
            fin_sat = 32'sh7FFF_FFFF;
        end else if (fin_sum < -54'sd2147483648) begin
            fin_sat = 32'sh8000_0000;
        end else begin
            fin_sat = fin_sum[31:0];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_shape_count <= '0;
            r_pacc        <= '0;
            r_nacc        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_shape_count <= i_cfg_data;
            end
            // A taken result word leaves unless a new one replaces it.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_item <= i_in_data;
                        case (i_in_data.opcode)
                            OP_COMMIT: begin
                                r_t     <= T_INIT;
                                r_cnt   <= '0;
                                r_state <= (count_used == '0) ? S_ROOT_GO : S_SUM_RD;
                            end
                            OP_TERM: begin
                                r_fin_sel <= 1'b0;
                                if ({1'b0, i_in_data.shape_index} < count_used) begin
                                    r_state <= S_TERM_RD;
                                end else if (i_in_data.last_term) begin
                                    r_state <= S_FIN_MAG;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_MUL;
                end
                S_SUM_MUL: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_t   <= r_t + r_prod[T_W-1:0];
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_state <= (r_cnt + CNT_W'(1) == count_used) ? S_ROOT_GO : S_SUM_RD;
                end
                S_ROOT_GO: begin
                    r_state <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT: begin
                    if (root_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_TERM_RD: begin
                    r_state <= S_TERM_MP;
                end
                S_TERM_MP: begin
                    r_state <= S_TERM_MN;
                end
                S_TERM_MN: begin
                    r_pacc  <= sat_add(r_pacc, r_prod);
                    r_state <= S_TERM_AN;
                end
                S_TERM_AN: begin
                    r_nacc  <= sat_add(r_nacc, r_prod);
                    r_state <= r_item.last_term ? S_FIN_MAG : S_IDLE;
                end
                S_FIN_MAG: begin
                    r_neg   <= fin_acc[63];
                    r_mag   <= fin_acc[63] ? (64'd0 - fin_acc) : fin_acc;
                    r_state <= S_FIN_LO;
                end
                S_FIN_LO: begin
                    r_state <= S_FIN_HI;
                end
                S_FIN_HI: begin
                    r_lo    <= {1'b0, r_prod[63:0]} + ROUND_HALF;
                    r_state <= S_FIN_ADD;
                end
                S_FIN_ADD: begin
                    r_full  <= {r_prod[63:0], 32'd0} + {31'd0, r_lo};
                    r_state <= S_FIN_SAT;
                end
                S_FIN_SAT: begin
                    if (r_fin_sel) begin
                        r_nrm_res <= fin_sat;
                        r_state   <= S_OUT;
                    end else begin
                        r_pos_res <= fin_sat;
                        r_fin_sel <= 1'b1;
                        r_state   <= S_FIN_MAG;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.position_out <= r_pos_res;
                        r_out.normal_out   <= r_nrm_res;
                        r_out.frame_end    <= r_item.last_component;
                        r_out_valid        <= 1'b1;
                        r_pacc             <= '0;
                        r_nacc             <= '0;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Scale computation over the committed sum of squares.
    nbm_rsqrt u_rsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_t     (r_t),
        .o_done  (root_done),
        .o_scale (scale)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/nbm_checker.sv =====
// ----------------------------------------------------------------------------
// nbm_checker
// Port-level checks of the blendshape mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "normalized_blendshape_mix_unit_assert.svh"

module nbm_checker
    import nbm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    // A stalled result word holds.
    `NBM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // A commit always occupies the block for the following cycle.
    `NBM_ASSERT_NEXT(a_commit_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.opcode == OP_COMMIT, o_in_stall)

    // A weight load never stalls the next word.
    `NBM_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.opcode == OP_LOAD, !o_in_stall)

    // A new result word appears only as the block returns to accepting input.
    `NBM_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, $rose(o_out_valid), !o_in_stall)

endmodule

bind normalized_blendshape_mix_unit nbm_checker u_nbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
